@@ rtl/ostt_pkg.sv @@
// -----------------------------------------------------------------------------
// ostt_pkg
// Shared types, constants and control structs for the one-shot timer table.
// -----------------------------------------------------------------------------
package ostt_pkg;

  // Table geometry
  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // At most this many slots fire on one expiry check
  localparam int unsigned MAX_FIRE = 16;
  localparam int unsigned FIRE_W   = $clog2(MAX_FIRE + 1);

  // A deadline is due when (now - deadline) mod 2^32 is below this
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  localparam slot_idx_t LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  // Request codes
  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_CANCEL   = 2'd1,
    REQ_EXPIRE   = 2'd2
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_REGISTERED = 3'd0,
    ST_REJECTED   = 3'd1,
    ST_CANCELLED  = 3'd2,
    ST_IGNORED    = 3'd3,
    ST_FIRED      = 3'd4,
    ST_NONE_DUE   = 3'd5
  } status_e;

  typedef struct packed {
    req_e        req_type;
    logic [31:0] current_time;
    logic [31:0] delay;
    logic [4:0]  slot_id;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic        compare_armed;
    logic [31:0] compare_value;
    logic        last;
  } rsp_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic    capture;      // latch the request beat
    logic    find;         // probe the free-slot scan index
    logic    alloc;        // claim the probed slot
    logic    cancel;       // free the slot named in the request
    logic    scan_start;   // arm a deadline scan
    logic    fire_mode;    // scan fires due slots as it goes
    logic    scan_run;     // step the deadline scan
    logic    commit;       // load earliest / compare from the scan result
    logic    status_ld;    // load the pending status
    status_e status_val;
    logic    emit_single;  // send the single result
    logic    emit_step;    // walk the fired-slot mask
  } ctl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    req_e req_type;
    logic delay_zero;
    logic id_ok;
    logic slot_free;
    logic scan_at_last;
    logic need_recomp;
    logic scan_done;
    logic fire_mode;
    logic fire_none;
    logic can_load;
    logic emit_done;
  } dp_status_t;

endpackage

@@ rtl/ostt_req_if.sv @@
// -----------------------------------------------------------------------------
// ostt_req_if
// Request channel: valid/ready handshake with the timer request payload.
// -----------------------------------------------------------------------------
interface ostt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] current_time;
  logic [31:0] delay;
  logic [4:0]  slot_id;

  modport source (output valid, req_type, current_time, delay, slot_id, input ready);
  modport sink   (input valid, req_type, current_time, delay, slot_id, output ready);
endinterface

@@ rtl/ostt_rsp_if.sv @@
// -----------------------------------------------------------------------------
// ostt_rsp_if
// Result channel: valid/ready handshake with the timer result payload.
// -----------------------------------------------------------------------------
interface ostt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic        compare_armed;
  logic [31:0] compare_value;
  logic        last;

  modport source (output valid, status, slot, compare_armed, compare_value, last,
                  input ready);
  modport sink   (input valid, status, slot, compare_armed, compare_value, last,
                  output ready);
endinterface

@@ rtl/ostt_datapath.sv @@
// -----------------------------------------------------------------------------
// ostt_datapath
// Slot table, deadline memory, scan pipeline, compare state and result register.
// -----------------------------------------------------------------------------
module ostt_datapath import ostt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  req_t       req_i,
  input  ctl_cmd_t   cmd_i,
  output dp_status_t stat_o,
  input  logic       rsp_ready_i,
  output logic       rsp_valid_o,
  output rsp_t       rsp_o
);

  // Wrap-aware due test
  function automatic logic is_due(input logic [31:0] deadline, input logic [31:0] now);
    logic [31:0] diff;
    diff = now - deadline;
    return diff < HALF_RANGE;
  endfunction

  // Request and slot state
  req_t                  req_q;
  logic [31:0]           dl_q;
  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic [SLOT_COUNT-1:0] fired_q, fired_d;
  logic [31:0]           dl_mem [SLOT_COUNT];

  // Scan pipeline
  slot_idx_t   scan_idx_q, pipe_idx_q;
  logic        issue_done_q, pipe_vld_q, pipe_last_q, fire_mode_q;
  logic [31:0] rd_data_q;
  logic        best_vld_q;
  logic [31:0] best_q;
  logic [FIRE_W-1:0] fire_cnt_q;

  // Compare state
  logic        earliest_vld_q, armed_q;
  logic [31:0] earliest_q, armed_val_q;

  // Result staging
  status_e           status_q;
  slot_idx_t         slot_q, emit_idx_q;
  logic [FIRE_W-1:0] emit_left_q;
  logic              rsp_vld_q;
  rsp_t              rsp_q;

  slot_idx_t   cancel_idx;
  logic        issue, pipe_active, fire_hit, min_hit;
  logic        can_load, emit_fired, emit_load, single_load;
  logic [31:0] armed_val_d;

  assign cancel_idx  = SLOT_W'(req_q.slot_id);
  assign issue       = cmd_i.scan_run && !issue_done_q;
  assign pipe_active = active_q[pipe_idx_q];

  // Evaluate the slot read out last cycle
  assign fire_hit = pipe_vld_q && fire_mode_q && pipe_active &&
                    is_due(rd_data_q, req_q.current_time) &&
                    (fire_cnt_q < FIRE_W'(MAX_FIRE));
  assign min_hit  = pipe_vld_q && pipe_active && !fire_hit &&
                    (!best_vld_q || (rd_data_q < best_q));

  assign can_load    = !rsp_vld_q || rsp_ready_i;
  assign emit_fired  = fired_q[emit_idx_q];
  assign emit_load   = cmd_i.emit_step && emit_fired && can_load;
  assign single_load = cmd_i.emit_single && can_load;

  // Compare value after a recompute
  always_comb begin
    if (!best_vld_q) begin
      armed_val_d = '0;
    end else if (is_due(best_q, req_q.current_time)) begin
      armed_val_d = req_q.current_time + 32'd1;
    end else begin
      armed_val_d = best_q;
    end
  end

  // Active and fired bit updates
  always_comb begin
    active_d = active_q;
    if (cmd_i.alloc)  active_d[scan_idx_q] = 1'b1;
    if (cmd_i.cancel) active_d[cancel_idx] = 1'b0;
    if (fire_hit)     active_d[pipe_idx_q] = 1'b0;
  end

  always_comb begin
    fired_d = fired_q;
    if (cmd_i.scan_start) begin
      fired_d = '0;
    end else if (fire_hit) begin
      fired_d[pipe_idx_q] = 1'b1;
    end
  end

  // Status to the controller
  always_comb begin
    stat_o.req_type     = req_q.req_type;
    stat_o.delay_zero   = (req_q.delay == '0);
    stat_o.id_ok        = (32'(req_q.slot_id) < 32'(SLOT_COUNT));
    stat_o.slot_free    = !active_q[scan_idx_q];
    stat_o.scan_at_last = (scan_idx_q == LAST_SLOT);
    stat_o.need_recomp  = !earliest_vld_q || (dl_q < earliest_q);
    stat_o.scan_done    = pipe_vld_q && pipe_last_q;
    stat_o.fire_mode    = fire_mode_q;
    stat_o.fire_none    = (fire_cnt_q == '0);
    stat_o.can_load     = can_load;
    stat_o.emit_done    = emit_load && (emit_left_q == FIRE_W'(1));
  end

  // Deadline memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      dl_mem[scan_idx_q] <= dl_q;
    end
    if (issue) begin
      rd_data_q <= dl_mem[scan_idx_q];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= '0;
      fired_q        <= '0;
      scan_idx_q     <= '0;
      issue_done_q   <= 1'b0;
      pipe_vld_q     <= 1'b0;
      fire_mode_q    <= 1'b0;
      best_vld_q     <= 1'b0;
      fire_cnt_q     <= '0;
      earliest_vld_q <= 1'b0;
      earliest_q     <= '0;
      armed_q        <= 1'b0;
      armed_val_q    <= '0;
      emit_idx_q     <= '0;
      emit_left_q    <= '0;
      rsp_vld_q      <= 1'b0;
    end else begin
      active_q   <= active_d;
      fired_q    <= fired_d;
      pipe_vld_q <= issue;

      // Scan index: shared by free-slot probe and deadline scan
      if (cmd_i.capture || cmd_i.scan_start) begin
        scan_idx_q <= '0;
      end else if (cmd_i.find || issue) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end

      if (cmd_i.scan_start) begin
        issue_done_q <= 1'b0;
        fire_mode_q  <= cmd_i.fire_mode;
        best_vld_q   <= 1'b0;
        fire_cnt_q   <= '0;
        emit_idx_q   <= '0;
      end else begin
        if (issue && (scan_idx_q == LAST_SLOT)) issue_done_q <= 1'b1;
        if (min_hit)  best_vld_q <= 1'b1;
        if (fire_hit) fire_cnt_q <= fire_cnt_q + 1'b1;
        if (cmd_i.emit_step && (!emit_fired || can_load)) begin
          emit_idx_q <= emit_idx_q + 1'b1;
        end
      end

      // Recompute result into the compare state
      if (cmd_i.commit) begin
        earliest_vld_q <= best_vld_q;
        earliest_q     <= best_vld_q ? best_q : '0;
        armed_q        <= best_vld_q;
        armed_val_q    <= armed_val_d;
        emit_left_q    <= fire_cnt_q;
      end else if (emit_load) begin
        emit_left_q <= emit_left_q - 1'b1;
      end

      // Output register handshake
      if (single_load || emit_load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
      dl_q  <= req_i.current_time + req_i.delay;
    end

    pipe_idx_q  <= scan_idx_q;
    pipe_last_q <= (scan_idx_q == LAST_SLOT);

    if (min_hit) best_q <= rd_data_q;

    if (cmd_i.status_ld) status_q <= cmd_i.status_val;

    if (cmd_i.alloc) begin
      slot_q <= scan_idx_q;
    end else if (cmd_i.cancel) begin
      slot_q <= cancel_idx;
    end else if (cmd_i.status_ld) begin
      slot_q <= '0;
    end

    if (single_load) begin
      rsp_q <= '{status: status_q, slot: 4'(slot_q), compare_armed: armed_q,
                 compare_value: armed_val_q, last: 1'b1};
    end else if (emit_load) begin
      rsp_q <= '{status: ST_FIRED, slot: 4'(emit_idx_q), compare_armed: armed_q,
                 compare_value: armed_val_q, last: (emit_left_q == FIRE_W'(1))};
    end
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

endmodule

@@ rtl/ostt_ctrl.sv @@
// -----------------------------------------------------------------------------
// ostt_ctrl
// Request sequencer: decode, free-slot probe, deadline scan, commit, results.
// -----------------------------------------------------------------------------
module ostt_ctrl import ostt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t stat_i,
  output ctl_cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_FIND   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_COMMIT = 7'b0010000,
    S_RESP   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.req_type)
          REQ_REGISTER: begin
            if (stat_i.delay_zero) begin
              cmd_o.status_ld  = 1'b1;
              cmd_o.status_val = ST_REJECTED;
              state_d          = S_RESP;
            end else begin
              state_d = S_FIND;
            end
          end
          REQ_CANCEL: begin
            cmd_o.status_ld = 1'b1;
            if (stat_i.id_ok) begin
              cmd_o.cancel     = 1'b1;
              cmd_o.status_val = ST_CANCELLED;
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end else begin
              cmd_o.status_val = ST_IGNORED;
              state_d          = S_RESP;
            end
          end
          REQ_EXPIRE: begin
            cmd_o.scan_start = 1'b1;
            cmd_o.fire_mode  = 1'b1;
            state_d          = S_SCAN;
          end
          default: begin
            // undefined request: dropped without a result
            state_d = S_IDLE;
          end
        endcase
      end
      S_FIND: begin
        cmd_o.find = 1'b1;
        if (stat_i.slot_free) begin
          cmd_o.alloc      = 1'b1;
          cmd_o.status_ld  = 1'b1;
          cmd_o.status_val = ST_REGISTERED;
          if (stat_i.need_recomp) begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end else if (stat_i.scan_at_last) begin
          // table full
          cmd_o.status_ld  = 1'b1;
          cmd_o.status_val = ST_REJECTED;
          state_d          = S_RESP;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat_i.fire_mode && stat_i.fire_none) begin
          // nothing due: compare left as is
          cmd_o.status_ld  = 1'b1;
          cmd_o.status_val = ST_NONE_DUE;
          state_d          = S_RESP;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = stat_i.fire_mode ? S_EMIT : S_RESP;
        end
      end
      S_RESP: begin
        cmd_o.emit_single = 1'b1;
        if (stat_i.can_load) state_d = S_IDLE;
      end
      S_EMIT: begin
        cmd_o.emit_step = 1'b1;
        if (stat_i.emit_done) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/one_shot_timer_table.sv @@
// -----------------------------------------------------------------------------
// one_shot_timer_table
// Table of one-shot timer slots sharing one hardware compare.
// -----------------------------------------------------------------------------
// Requests are taken one at a time: register (lowest free slot gets deadline
// current_time+delay), cancel (frees a slot and recomputes the compare), and
// expiry check (fires every due slot, at most 16, lowest first, one result
// beat per fired slot). All result beats of a request carry the compare state
// after the whole request, and the final beat has last set. A register probes
// slots from slot 0 up for a free one and rescans the deadlines only when the
// new deadline becomes the earliest; a valid cancel always rescans; an expiry
// check scans every slot and, when any fired, walks the fired-slot mask up to
// the highest fired slot. The slot scan visits one slot per cycle through the
// single read port of the deadline memory, and a result side that holds off
// delays the block further. A finished beat waits in the output register
// while the next request is accepted.
// -----------------------------------------------------------------------------
module one_shot_timer_table import ostt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  ostt_req_if.sink   req_i,
  ostt_rsp_if.source rsp_o
);

  req_t       req_pl;
  rsp_t       rsp_pl;
  ctl_cmd_t   cmd;
  dp_status_t stat;
  logic       in_ready;
  logic       rsp_valid;

  // Pack the request beat
  assign req_pl.req_type     = req_e'(req_i.req_type);
  assign req_pl.current_time = req_i.current_time;
  assign req_pl.delay        = req_i.delay;
  assign req_pl.slot_id      = req_i.slot_id;
  assign req_i.ready         = in_ready;

  ostt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ostt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_pl),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp_pl)
  );

  // Unpack the result beat
  assign rsp_o.valid         = rsp_valid;
  assign rsp_o.status        = rsp_pl.status;
  assign rsp_o.slot          = rsp_pl.slot;
  assign rsp_o.compare_armed = rsp_pl.compare_armed;
  assign rsp_o.compare_value = rsp_pl.compare_value;
  assign rsp_o.last          = rsp_pl.last;

endmodule

@@ rtl/ostt_checker.sv @@
// -----------------------------------------------------------------------------
// ostt_checker
// Port-level checks for the one-shot timer table, bound to the top level.
// -----------------------------------------------------------------------------
module ostt_checker import ostt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic [1:0]  req_type_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_status_i,
  input logic [3:0]  rsp_slot_i,
  input logic        rsp_armed_i,
  input logic [31:0] rsp_value_i,
  input logic        rsp_last_i
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_slot_i) && $stable(rsp_value_i) && $stable(rsp_last_i))
    else $error("result beat changed while stalled");

  // Only fired-slot beats can be followed by more beats of the same request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_FIRED) |-> rsp_last_i)
    else $error("single-result status without last");

  // Results without a slot report slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_REJECTED || rsp_status_i == ST_IGNORED ||
                    rsp_status_i == ST_NONE_DUE) |-> (rsp_slot_i == '0))
    else $error("nonzero slot on slotless status");

  // A disarmed compare reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_armed_i |-> (rsp_value_i == '0))
    else $error("disarmed compare with nonzero value");

  // A valid request keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i &&
      (req_type_i == REQ_REGISTER || req_type_i == REQ_CANCEL ||
       req_type_i == REQ_EXPIRE) |=> !req_ready_i)
    else $error("request accepted while previous one in progress");

endmodule

bind one_shot_timer_table ostt_checker u_ostt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_slot_i   (rsp_o.slot),
  .rsp_armed_i  (rsp_o.compare_armed),
  .rsp_value_i  (rsp_o.compare_value),
  .rsp_last_i   (rsp_o.last)
);

@@ dv/tb_one_shot_timer_table.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_one_shot_timer_table
// Self-checking bench for the one-shot timer table. A short directed table
// covers the corner cases: empty table, zero delay, full table, out-of-range
// and inactive cancels, all-ones deadlines, wrap of the time base and bulk
// expiry. Random timer traffic follows with a moving time base. Every result
// beat is checked field by field against a typed row or a bench slot table,
// with random idling on both channels and one long result-side stall.
// -----------------------------------------------------------------------------
module tb_one_shot_timer_table;
  import ostt_pkg::*;

  // Undefined request code; the block drops it without a result
  localparam logic [1:0] REQ_UNDEFINED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned STALL_CYCLES = 300;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] now;
    logic [31:0] delay;
    logic [4:0]  id;
  } timer_req_t;

  // Directed row: request, repeat count (delay steps by 37 per repeat) and,
  // where typed is set, the single result beat expected
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now;
    logic [31:0] delay;
    logic [4:0]  id;
    logic [4:0]  reps;
    logic        typed;
    status_e     st;
    logic [3:0]  sl;
    logic        armed;
    logic [31:0] val;
  } dir_row_t;

  localparam int unsigned N_DIRECTED = 18;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // empty table
    '{REQ_EXPIRE,   32'd100,        32'd0,        5'd0,  5'd1,  1'b1, ST_NONE_DUE,   4'd0,
      1'b0, 32'd0},
    '{REQ_CANCEL,   32'd100,        32'd0,        5'd16, 5'd1,  1'b1, ST_IGNORED,    4'd0,
      1'b0, 32'd0},
    '{REQ_CANCEL,   32'd100,        32'hFFFF_FFFF, 5'd31, 5'd1, 1'b1, ST_IGNORED,    4'd0,
      1'b0, 32'd0},
    '{REQ_REGISTER, 32'd5,          32'd0,        5'd31, 5'd1,  1'b1, ST_REJECTED,   4'd0,
      1'b0, 32'd0},
    '{REQ_CANCEL,   32'd7,          32'd0,        5'd3,  5'd1,  1'b1, ST_CANCELLED,  4'd3,
      1'b0, 32'd0},
    // first deadline arms the compare; an all-ones deadline is not earlier
    '{REQ_REGISTER, 32'd0,          32'd1,        5'd0,  5'd1,  1'b1, ST_REGISTERED, 4'd0,
      1'b1, 32'd1},
    '{REQ_REGISTER, 32'd0,          32'hFFFF_FFFF, 5'd0, 5'd1,  1'b1, ST_REGISTERED, 4'd1,
      1'b1, 32'd1},
    '{REQ_UNDEFINED, 32'd0,         32'd1,        5'd31, 5'd1,  1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0},
    '{REQ_EXPIRE,   32'd0,          32'd0,        5'd0,  5'd1,  1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0},
    // deadline wraps across the half range
    '{REQ_REGISTER, 32'h7FFF_FFF0,  32'h20,       5'd0,  5'd1,  1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0},
    '{REQ_EXPIRE,   32'h8000_0010,  32'd0,        5'd0,  5'd1,  1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0},
    '{REQ_CANCEL,   32'h8000_0011,  32'd0,        5'd15, 5'd1,  1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0},
    // fill the table, then one more register is refused
    '{REQ_REGISTER, 32'd1000,       32'd50,       5'd0,  5'd15, 1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0},
    '{REQ_REGISTER, 32'd1000,       32'd5,        5'd0,  5'd1,  1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0},
    '{REQ_CANCEL,   32'd1001,       32'd0,        5'd15, 5'd1,  1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0},
    '{REQ_REGISTER, 32'hFFFF_FFFF,  32'hFFFF_FFFF, 5'd0, 5'd1,  1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0},
    // expiry of the all-ones deadline, then a bulk expiry clears the rest
    '{REQ_EXPIRE,   32'hFFFF_FFFF,  32'd0,        5'd0,  5'd1,  1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0},
    '{REQ_EXPIRE,   32'h4000_0000,  32'd0,        5'd0,  5'd1,  1'b0, ST_REGISTERED, 4'd0,
      1'b0, 32'd0}
  };

  logic clk;
  logic rst_n;

  ostt_req_if req_if ();
  ostt_rsp_if rsp_if ();

  one_shot_timer_table uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Bench copy of the slot table and compare state
  bit          slot_busy   [SLOT_COUNT];
  logic [31:0] slot_due_at [SLOT_COUNT];
  bit          earliest_ok = 1'b0;
  logic [31:0] earliest_at = '0;
  bit          cmp_armed   = 1'b0;
  logic [31:0] cmp_value   = '0;

  rsp_t        timer_rsp_q [$];
  int unsigned n_errors = 0;
  int unsigned n_sent   = 0;
  bit          quiet    = 1'b0;
  logic [31:0] wall_us  = '0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5ms;
    $display("tb_one_shot_timer_table: errors");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns mismatch %s: got %h want %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Wrap-aware due test: (now - deadline) mod 2^32 below half range
  function automatic bit deadline_reached(logic [31:0] dl, logic [31:0] now);
    logic [31:0] diff;
    diff = now - dl;
    return diff < HALF_RANGE;
  endfunction

  // Earliest active deadline by plain unsigned compare, then rearm
  function automatic void rescan_compare(logic [31:0] now);
    bit          found;
    logic [31:0] best;
    found = 1'b0;
    best  = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (slot_busy[k] && (!found || slot_due_at[k] < best)) begin
        best  = slot_due_at[k];
        found = 1'b1;
      end
    end
    earliest_ok = found;
    earliest_at = best;
    cmp_armed   = found;
    if (!found) cmp_value = '0;
    else if (deadline_reached(best, now)) cmp_value = now + 32'd1;
    else cmp_value = best;
  endfunction

  // Apply one request to the bench table and build its result beats
  function automatic void timer_table_apply(input timer_req_t s, output rsp_t beats[$]);
    status_e     st [$];
    logic [3:0]  sl [$];
    bit          placed;
    logic [31:0] dl;
    rsp_t        b;
    beats  = {};
    placed = 1'b0;
    case (s.kind)
      REQ_REGISTER: begin
        if (s.delay != '0) begin
          for (int k = 0; k < SLOT_COUNT; k++) begin
            if (!placed && !slot_busy[k]) begin
              dl             = s.now + s.delay;
              slot_busy[k]   = 1'b1;
              slot_due_at[k] = dl;
              if (!earliest_ok || dl < earliest_at) rescan_compare(s.now);
              st.push_back(ST_REGISTERED);
              sl.push_back(4'(k));
              placed = 1'b1;
            end
          end
        end
        if (!placed) begin
          st.push_back(ST_REJECTED);
          sl.push_back(4'd0);
        end
      end
      REQ_CANCEL: begin
        if (s.id < SLOT_COUNT) begin
          slot_busy[s.id] = 1'b0;
          rescan_compare(s.now);
          st.push_back(ST_CANCELLED);
          sl.push_back(4'(s.id));
        end else begin
          st.push_back(ST_IGNORED);
          sl.push_back(4'd0);
        end
      end
      REQ_EXPIRE: begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
          if (st.size() < MAX_FIRE && slot_busy[k] &&
              deadline_reached(slot_due_at[k], s.now)) begin
            slot_busy[k] = 1'b0;
            st.push_back(ST_FIRED);
            sl.push_back(4'(k));
          end
        end
        if (st.size() != 0) rescan_compare(s.now);
        else begin
          st.push_back(ST_NONE_DUE);
          sl.push_back(4'd0);
        end
      end
      default: ;
    endcase
    foreach (st[i]) begin
      b.status        = st[i];
      b.slot          = sl[i];
      b.compare_armed = cmp_armed;
      b.compare_value = cmp_value;
      b.last          = (i == st.size() - 1);
      beats.push_back(b);
    end
  endfunction

  // Random timer traffic on a moving time base
  function automatic timer_req_t random_request();
    timer_req_t s;
    int         pick;
    int         span;
    span = $urandom_range(0, 99);
    if (span < 90) wall_us = wall_us + 32'($urandom_range(0, 80));
    else if (span < 95) wall_us = $urandom();
    else wall_us = wall_us + 32'h7FFF_FFF0 + 32'($urandom_range(0, 32));
    s.now   = wall_us;
    s.delay = $urandom();
    s.id    = 5'($urandom_range(0, 31));
    pick    = $urandom_range(0, 99);
    if (pick < 40) begin
      s.kind = REQ_REGISTER;
      span   = $urandom_range(0, 99);
      if (span < 70) s.delay = 32'($urandom_range(1, 300));
      else if (span < 80) s.delay = '0;
      else if (span < 90) s.delay = 32'h7FFF_FFF0 + 32'($urandom_range(0, 32));
      else if (span < 95) s.delay = 32'hFFFF_FFFF;
    end else if (pick < 60) begin
      s.kind = REQ_CANCEL;
      if ($urandom_range(0, 99) < 85) s.id = 5'($urandom_range(0, SLOT_COUNT - 1));
    end else if (pick < 96) begin
      s.kind = REQ_EXPIRE;
    end else begin
      s.kind = REQ_UNDEFINED;
    end
    return s;
  endfunction

  // Offer one request beat, wait for acceptance, then queue its results
  task automatic push_request(input timer_req_t s, input bit typed, input rsp_t typed_beat);
    rsp_t beats [$];
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 30) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= s.kind;
    req_if.current_time <= s.now;
    req_if.delay        <= s.delay;
    req_if.slot_id      <= s.id;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    timer_table_apply(s, beats);
    if (typed) timer_rsp_q.push_back(typed_beat);
    else foreach (beats[i]) timer_rsp_q.push_back(beats[i]);
    n_sent++;
  endtask

  // Result side: random idling, one long hold-off once traffic is flowing
  initial begin : rsp_sink
    bit held_off;
    held_off     = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && n_sent >= 60) begin
        rsp_if.ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end else if (quiet) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (timer_rsp_q.size() == 0) begin
        report_mismatch("unexpected beat, status", 32'(rsp_if.status), '0);
      end else begin
        want = timer_rsp_q.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.slot !== want.slot)
          report_mismatch("slot", 32'(rsp_if.slot), 32'(want.slot));
        if (rsp_if.compare_armed !== want.compare_armed)
          report_mismatch("compare_armed", 32'(rsp_if.compare_armed),
                          32'(want.compare_armed));
        if (rsp_if.compare_value !== want.compare_value)
          report_mismatch("compare_value", rsp_if.compare_value, want.compare_value);
        if (rsp_if.last !== want.last)
          report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
      end
    end
  end

  // Reset, directed table, random traffic, drain
  initial begin : stimulus
    timer_req_t  s;
    rsp_t        typed_beat;
    int unsigned n_counted;
    int unsigned idx;
    int unsigned waited;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = '0;
    req_if.current_time = '0;
    req_if.delay        = '0;
    req_if.slot_id      = '0;
    foreach (slot_busy[k]) slot_busy[k] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      for (int r = 0; r < DIRECTED[i].reps; r++) begin
        s.kind                   = DIRECTED[i].kind;
        s.now                    = DIRECTED[i].now;
        s.delay                  = DIRECTED[i].delay + 32'(r * 37);
        s.id                     = DIRECTED[i].id;
        typed_beat.status        = DIRECTED[i].st;
        typed_beat.slot          = DIRECTED[i].sl;
        typed_beat.compare_armed = DIRECTED[i].armed;
        typed_beat.compare_value = DIRECTED[i].val;
        typed_beat.last          = 1'b1;
        push_request(s, DIRECTED[i].typed, typed_beat);
      end
    end

    // Random traffic; a middle stretch runs without idling
    wall_us   = 32'h0000_1000;
    n_counted = 0;
    idx       = 0;
    while (n_counted < RANDOM_ITEMS) begin
      quiet = (idx >= 110 && idx < 150);
      s     = random_request();
      push_request(s, 1'b0, typed_beat);
      if (s.kind != REQ_UNDEFINED) n_counted++;
      idx++;
    end
    quiet = 1'b0;
    @(negedge clk);
    req_if.valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    waited = 0;
    while (timer_rsp_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (timer_rsp_q.size() != 0)
      report_mismatch("beats never delivered", 32'(timer_rsp_q.size()), '0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("tb_one_shot_timer_table: clean");
    end else begin
      $display("tb_one_shot_timer_table: errors");
    end
    $finish;
  end

endmodule
